### design/tctg_pkg.sv
// ----------------------------------------------------------------------------
// Tilt tone generator package
// Shared widths, token types, register indexes, the arctangent table and the
// quarter-wave sine table built at elaboration.
// ----------------------------------------------------------------------------
package tctg_pkg;

	localparam int PHASE_BITS        = 32;
	localparam int ANGLE_BITS        = 16;
	localparam int CORDIC_ITERATIONS = 16;
	localparam int SINE_TABLE_BITS   = 10;

	localparam int SINE_N       = 1 << SINE_TABLE_BITS;
	localparam int ATAN_ENTRIES = 24;
	localparam int ATAN_W       = 30;
	localparam int ITER_W       = 5;
	localparam int CW           = 34;   // CORDIC datapath width, signed
	localparam int COORD_W      = 16;
	localparam int SCALE_SHIFT  = 14;
	localparam int VOL_W        = 15;
	localparam int MAG_W        = 15;
	localparam int SAMPLE_W     = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 32;
	localparam int PROD_W       = PHASE_BITS + ANGLE_BITS;

	localparam longint GAIN_INV_Q30 = 64'sd652032874;

	localparam logic [7:0]              START_MARK   = 8'hAA;
	localparam logic [VOL_W-1:0]        VOLUME_RST   = VOL_W'(9830);
	localparam logic [PHASE_BITS-1:0]   MIN_STEP_RST = PHASE_BITS'(21426140);
	localparam logic [PHASE_BITS-1:0]   SPAN_STEP_RST = PHASE_BITS'(64278421);
	localparam logic [PHASE_BITS-1:0]   STEP_RST     = PHASE_BITS'(42852281);

	localparam logic signed [CW-1:0] Z_HALF = CW'(64'sd1 <<< 31);

	// frame position codes
	localparam logic [2:0] FRAME_HUNT      = 3'd0;
	localparam logic [2:0] FRAME_COORD_END = 3'd4;
	localparam logic [2:0] FRAME_LAST      = 3'd6;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VOLUME    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_SPAN_STEP = CFG_IDX_W'(2);

	typedef enum logic [1:0] {
		SPEC_NONE,
		SPEC_MID,
		SPEC_TOP
	} angle_spec_t;

	// token moving down the CORDIC chain: a tick or a completed frame
	typedef struct packed {
		logic               valid;
		logic               frame;
		angle_spec_t        spec;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} cor_tok_t;

	// finished sample
	typedef struct packed {
		logic                       valid;
		logic signed [SAMPLE_W-1:0] sample;
		logic [PHASE_BITS-1:0]      step;
	} tone_tok_t;

	typedef logic [MAG_W-1:0] sine_tab_t [0:SINE_N];

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [ATAN_W-1:0] atan_f(input logic [ITER_W-1:0] i);
		logic [ATAN_W-1:0] a;
		unique case (i)
			5'd0:  a = 30'h20000000;
			5'd1:  a = 30'h12E4051E;
			5'd2:  a = 30'h09FB385B;
			5'd3:  a = 30'h051111D4;
			5'd4:  a = 30'h028B0D43;
			5'd5:  a = 30'h0145D7E1;
			5'd6:  a = 30'h00A2F61E;
			5'd7:  a = 30'h00517C55;
			5'd8:  a = 30'h0028BE53;
			5'd9:  a = 30'h00145F2F;
			5'd10: a = 30'h000A2F98;
			5'd11: a = 30'h000517CC;
			5'd12: a = 30'h00028BE6;
			5'd13: a = 30'h000145F3;
			5'd14: a = 30'h0000A2FA;
			5'd15: a = 30'h0000517D;
			5'd16: a = 30'h000028BE;
			5'd17: a = 30'h0000145F;
			5'd18: a = 30'h00000A30;
			5'd19: a = 30'h00000518;
			5'd20: a = 30'h0000028C;
			5'd21: a = 30'h00000146;
			5'd22: a = 30'h000000A3;
			5'd23: a = 30'h00000051;
			default: a = '0;
		endcase
		return a;
	endfunction

	// quarter-wave table, evaluated once at elaboration
	function automatic sine_tab_t sine_tab_build();
		sine_tab_t t;
		longint    x;
		longint    y;
		longint    z;
		longint    xs;
		longint    ys;
		longint    r;
		for (int k = 0; k <= SINE_N; k++) begin
			x = GAIN_INV_Q30;
			y = 0;
			z = longint'(k) <<< (30 - SINE_TABLE_BITS);
			for (int i = 0; i < ATAN_ENTRIES; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (z >= 0) begin
					x = x - ys;
					y = y + xs;
					z = z - longint'(atan_f(ITER_W'(i)));
				end else begin
					x = x + ys;
					y = y - xs;
					z = z + longint'(atan_f(ITER_W'(i)));
				end
			end
			if (y < 0)
				y = 0;
			r = (y + 16384) >>> 15;
			if (r > 32767)
				r = 32767;
			t[k] = MAG_W'(r);
		end
		return t;
	endfunction

	localparam sine_tab_t SINE_TAB = sine_tab_build();

endpackage

### design/tctg_intf.sv
// ----------------------------------------------------------------------------
// Tilt tone generator channels
// Item, sample and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tctg_item_if;
	import tctg_pkg::*;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;
	modport source (output valid, action, data_byte, input ready);
	modport sink (input valid, action, data_byte, output ready);
endinterface

interface tctg_sample_if;
	import tctg_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic [PHASE_BITS-1:0]      tone_step;
	modport source (output valid, sample, tone_step, input ready);
	modport sink (input valid, sample, tone_step, output ready);
endinterface

interface tctg_cfg_if;
	import tctg_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### design/tctg_frame.sv
// ----------------------------------------------------------------------------
// Tilt tone generator frame parser
// Hunts for the start byte, collects x and y, and launches a token for each
// tick and each completed frame into the CORDIC chain.
// ----------------------------------------------------------------------------
module tctg_frame (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             acc,
	input  logic             action,
	input  logic [7:0]       data_byte,
	output tctg_pkg::cor_tok_t tok
);
	import tctg_pkg::*;

	logic [2:0]          pos_q;
	logic [31:0]         coord_q;
	logic                valid_q;
	cor_tok_t            pay_q;
	logic                in_frame;
	logic [1:0]          byte_sel;
	logic signed [COORD_W-1:0] xi;
	logic signed [COORD_W-1:0] yi;
	logic signed [COORD_W:0]   xn;
	logic signed [COORD_W:0]   yn;
	cor_tok_t            pre;
	logic                launch;

	assign in_frame = (pos_q != FRAME_HUNT) && (pos_q <= FRAME_LAST);
	assign byte_sel = 2'(pos_q - 3'd1);
	assign launch   = acc && (action || (in_frame && (pos_q == FRAME_LAST)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= FRAME_HUNT;
			coord_q <= '0;
		end else if (acc && !action) begin
			if (!in_frame) begin
				pos_q <= (data_byte == START_MARK) ? 3'd1 : FRAME_HUNT;
			end else begin
				if (pos_q <= FRAME_COORD_END)
					coord_q[8*byte_sel +: 8] <= data_byte;
				if (pos_q == FRAME_LAST)
					pos_q <= FRAME_HUNT;
				else
					pos_q <= pos_q + 3'd1;
			end
		end
	end

	// fold the left half-plane onto the right one and scale up
	always_comb begin
		xi = $signed(coord_q[15:0]);
		yi = $signed(coord_q[31:16]);
		pre       = '0;
		pre.valid = 1'b1;
		pre.frame = !action;
		if (xi == 0 && yi == 0)
			pre.spec = SPEC_MID;
		else if (yi == 0 && xi < 0)
			pre.spec = SPEC_TOP;
		else
			pre.spec = SPEC_NONE;
		if (xi < 0) begin
			xn    = -{xi[COORD_W-1], xi};
			yn    = -{yi[COORD_W-1], yi};
			pre.z = (yi >= 0) ? Z_HALF : -Z_HALF;
		end else begin
			xn    = {xi[COORD_W-1], xi};
			yn    = {yi[COORD_W-1], yi};
			pre.z = '0;
		end
		pre.x = {{(CW-COORD_W-1-SCALE_SHIFT){xn[COORD_W]}}, xn, {SCALE_SHIFT{1'b0}}};
		pre.y = {{(CW-COORD_W-1-SCALE_SHIFT){yn[COORD_W]}}, yn, {SCALE_SHIFT{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (en)
			valid_q <= launch;
	end

	always_ff @(posedge clk) begin
		if (en)
			pay_q <= pre;
	end

	always_comb begin
		tok       = pay_q;
		tok.valid = valid_q;
	end

endmodule

### design/tctg_cordic_cell.sv
// ----------------------------------------------------------------------------
// Tilt tone generator CORDIC cell
// One vectoring micro-rotation per cell; hands its token to the next cell.
// ----------------------------------------------------------------------------
module tctg_cordic_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [tctg_pkg::ITER_W-1:0] iter,
	input  tctg_pkg::cor_tok_t          tok_in,
	output tctg_pkg::cor_tok_t          tok_out
);
	import tctg_pkg::*;

	logic signed [CW-1:0] xi;
	logic signed [CW-1:0] yi;
	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic signed [CW-1:0] at;
	cor_tok_t             nxt;
	logic                 valid_q;
	cor_tok_t             pay_q;

	always_comb begin
		xi  = tok_in.x;
		yi  = tok_in.y;
		xs  = xi >>> iter;
		ys  = yi >>> iter;
		at  = $signed({{(CW-ATAN_W){1'b0}}, atan_f(iter)});
		nxt = tok_in;
		// rotate towards the x axis
		if (yi > 0) begin
			nxt.x = xi + ys;
			nxt.y = yi - xs;
			nxt.z = tok_in.z + at;
		end else begin
			nxt.x = xi - ys;
			nxt.y = yi + xs;
			nxt.z = tok_in.z - at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (en)
			valid_q <= tok_in.valid;
	end

	always_ff @(posedge clk) begin
		if (en)
			pay_q <= nxt;
	end

	always_comb begin
		tok_out       = pay_q;
		tok_out.valid = valid_q;
	end

endmodule

### design/tctg_tone.sv
// ----------------------------------------------------------------------------
// Tilt tone generator tone back end
// Angle code, step update, phase accumulator, sine lookup and volume scaling.
// ----------------------------------------------------------------------------
module tctg_tone (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  tctg_pkg::cor_tok_t              tok,
	input  logic [tctg_pkg::VOL_W-1:0]      volume,
	input  logic [tctg_pkg::PHASE_BITS-1:0] min_step,
	input  logic [tctg_pkg::PHASE_BITS-1:0] span_step,
	output tctg_pkg::tone_tok_t             res
);
	import tctg_pkg::*;

	// s1: angle code
	logic signed [CW:0]      u;
	logic [31:0]             uc;
	logic [32:0]             rnd;
	logic [ANGLE_BITS:0]     code_w;
	logic [ANGLE_BITS-1:0]   code;
	logic                    v_s1;
	logic                    frame_s1;
	logic [ANGLE_BITS-1:0]   code_s1;

	// s2: span product
	logic                    v_s2;
	logic                    frame_s2;
	logic [PROD_W-1:0]       prod_s2;

	// s3: step and phase
	logic [PHASE_BITS:0]     step_sum;
	logic [PHASE_BITS-1:0]   step_q;
	logic [PHASE_BITS-1:0]   phase_q;
	logic                    v_s3;
	logic [PHASE_BITS-1:0]   ph_s3;
	logic [PHASE_BITS-1:0]   step_s3;

	// s4: table read
	logic [1:0]                 quad;
	logic [SINE_TABLE_BITS-1:0] k;
	logic [SINE_TABLE_BITS:0]   idx;
	logic                       v_s4;
	logic                       neg_s4;
	logic [MAG_W-1:0]           mag_s4;
	logic [PHASE_BITS-1:0]      step_s4;

	// s5: volume
	logic [VOL_W+MAG_W-1:0]     vm;
	logic [SAMPLE_W-1:0]        mag16;
	logic                       v_s5;
	logic signed [SAMPLE_W-1:0] sample_s5;
	logic [PHASE_BITS-1:0]      step_s5;

	always_comb begin
		u = {tok.z[CW-1], tok.z} + $signed((CW+1)'(64'sd1 <<< 31));
		if (u < 0)
			uc = '0;
		else if (u > $signed((CW+1)'(64'hFFFF_FFFF)))
			uc = '1;
		else
			uc = u[31:0];
		rnd    = {1'b0, uc} + 33'(64'd1 << (31 - ANGLE_BITS));
		code_w = rnd[32 -: (ANGLE_BITS+1)];
		unique case (tok.spec)
			SPEC_MID: code = ANGLE_BITS'(64'd1 << (ANGLE_BITS - 1));
			SPEC_TOP: code = '1;
			default:  code = code_w[ANGLE_BITS] ? '1 : code_w[ANGLE_BITS-1:0];
		endcase
	end

	assign step_sum = {1'b0, min_step} + {1'b0, prod_s2[PROD_W-1 -: PHASE_BITS]};

	always_comb begin
		quad = ph_s3[PHASE_BITS-1 -: 2];
		k    = ph_s3[PHASE_BITS-3 -: SINE_TABLE_BITS];
		idx  = quad[0] ? ((SINE_TABLE_BITS+1)'(SINE_N) - {1'b0, k}) : {1'b0, k};
	end

	always_comb begin
		vm    = volume * mag_s4 + (VOL_W+MAG_W)'(16384);
		mag16 = {1'b0, vm[VOL_W+MAG_W-1 -: MAG_W]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			step_q  <= STEP_RST;
			phase_q <= '0;
		end else if (en) begin
			v_s1 <= tok.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && !frame_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			if (v_s2 && frame_s2)
				step_q <= step_sum[PHASE_BITS] ? '1 : step_sum[PHASE_BITS-1:0];
			if (v_s2 && !frame_s2)
				phase_q <= phase_q + step_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			frame_s1  <= tok.frame;
			code_s1   <= code;
			frame_s2  <= frame_s1;
			prod_s2   <= span_step * code_s1;
			ph_s3     <= phase_q;
			step_s3   <= step_q;
			neg_s4    <= quad[1];
			mag_s4    <= SINE_TAB[idx];
			step_s4   <= step_s3;
			sample_s5 <= neg_s4 ? -$signed(mag16) : $signed(mag16);
			step_s5   <= step_s4;
		end
	end

	always_comb begin
		res.valid  = v_s5;
		res.sample = sample_s5;
		res.step   = step_s5;
	end

endmodule

### design/tilt_controlled_tone_generator.sv
// ----------------------------------------------------------------------------
// Tilt-controlled tone generator
// Framed tilt bytes steer the pitch of a sine oscillator through an atan2.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle, byte or tick, while the skid slot is empty; ticks and
//   completed frames travel in order through the 16-cell CORDIC chain.
// Path: a tick passes the frame register, 16 cells, stages s1-s5 and the output register.
// Reset: hunting for a start byte, phase 0, step 42852281, registers
//   at their defaults; no clearing pass, items are taken from the first cycle.
module tilt_controlled_tone_generator (
	input  logic           clk,
	input  logic           arst_n,
	tctg_item_if.sink      byte_tick,
	tctg_sample_if.source  tone,
	tctg_cfg_if.sink       cfg
);
	import tctg_pkg::*;

	logic [VOL_W-1:0]      volume_q;
	logic [PHASE_BITS-1:0] min_step_q;
	logic [PHASE_BITS-1:0] span_step_q;

	logic       en;
	logic       acc;
	cor_tok_t   chain [0:CORDIC_ITERATIONS];
	tone_tok_t  res;

	logic       out_v_q;
	tone_tok_t  out_q;
	logic       skid_v_q;
	tone_tok_t  skid_q;

	// The whole pipeline advances together; it holds only once the skid
	// slot is taken, so ready never waits on the sample side combinationally.
	assign en              = !skid_v_q;
	assign byte_tick.ready = en;
	assign acc             = byte_tick.valid && en;

	// Configuration: always ready, writes land at once.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q    <= VOLUME_RST;
			min_step_q  <= MIN_STEP_RST;
			span_step_q <= SPAN_STEP_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_VOLUME:    volume_q    <= cfg.data[VOL_W-1:0];
				REG_MIN_STEP:  min_step_q  <= cfg.data[PHASE_BITS-1:0];
				REG_SPAN_STEP: span_step_q <= cfg.data[PHASE_BITS-1:0];
				default: ;   // drop writes beyond the register list
			endcase
		end
	end

	// Frame parser: ticks and completed frames enter the chain as tokens,
	// other bytes only advance the frame state.
	tctg_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.acc       (acc),
		.action    (byte_tick.action),
		.data_byte (byte_tick.data_byte),
		.tok       (chain[0])
	);

	// CORDIC vectoring chain: one micro-rotation per cell. Ticks ride along
	// so that a tick following a frame sees the step that frame produced.
	for (genvar g = 0; g < CORDIC_ITERATIONS; g++) begin : g_cell
		tctg_cordic_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.iter    (ITER_W'(g)),
			.tok_in  (chain[g]),
			.tok_out (chain[g+1])
		);
	end

	// Angle code, step register, phase accumulator and sine output.
	tctg_tone u_tone (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.tok       (chain[CORDIC_ITERATIONS]),
		.volume    (volume_q),
		.min_step  (min_step_q),
		.span_step (span_step_q),
		.res       (res)
	);

	// Output register with skid slot: a sample pushed while the output
	// transaction stalls is parked in the skid slot, which in turn holds the
	// pipeline until it drains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (tone.ready)
				skid_v_q <= 1'b0;
		end else if (res.valid) begin
			if (out_v_q && !tone.ready)
				skid_v_q <= 1'b1;
			else
				out_v_q <= 1'b1;
		end else if (tone.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (tone.ready)
				out_q <= skid_q;
		end else if (res.valid) begin
			if (out_v_q && !tone.ready)
				skid_q <= res;
			else
				out_q <= res;
		end
	end

	assign tone.valid     = out_v_q;
	assign tone.sample    = out_q.sample;
	assign tone.tone_step = out_q.step;

endmodule
